FILE: design/tksd_pkg.sv
// Package for the terminal key sequence decoder.
// Holds the payload and control types, the key codes and the byte decode functions.
// Has no dependencies; every design file imports it.
package tksd_pkg;

	localparam int DEF_MAX_PENDING = 16;
	localparam int DEF_PARAM_BITS  = 16;
	localparam int RESULT_LIMIT    = 16;

	// Key codes on the output.
	localparam logic [5:0] KEY_CHAR      = 6'd0;
	localparam logic [5:0] KEY_UP        = 6'd1;
	localparam logic [5:0] KEY_DOWN      = 6'd2;
	localparam logic [5:0] KEY_LEFT      = 6'd3;
	localparam logic [5:0] KEY_RIGHT     = 6'd4;
	localparam logic [5:0] KEY_ENTER     = 6'd5;
	localparam logic [5:0] KEY_ESCAPE    = 6'd6;
	localparam logic [5:0] KEY_TAB       = 6'd7;
	localparam logic [5:0] KEY_BACKTAB   = 6'd8;
	localparam logic [5:0] KEY_BACKSPACE = 6'd9;
	localparam logic [5:0] KEY_DELETE    = 6'd10;
	localparam logic [5:0] KEY_INSERT    = 6'd11;
	localparam logic [5:0] KEY_PAGEUP    = 6'd12;
	localparam logic [5:0] KEY_PAGEDOWN  = 6'd13;
	localparam logic [5:0] KEY_HOME      = 6'd14;
	localparam logic [5:0] KEY_END       = 6'd15;
	localparam logic [5:0] KEY_CTRL_C    = 6'd16;
	localparam logic [5:0] KEY_CTRL_D    = 6'd17;
	localparam logic [5:0] KEY_CTRL_L    = 6'd18;
	localparam logic [5:0] KEY_CTRL_R    = 6'd19;
	localparam logic [5:0] KEY_CTRL_U    = 6'd20;
	localparam logic [5:0] KEY_CTRL_W    = 6'd21;
	localparam logic [5:0] KEY_CTRL_Z    = 6'd22;
	localparam logic [5:0] KEY_F1        = 6'd23;
	localparam logic [5:0] KEY_F2        = 6'd24;
	localparam logic [5:0] KEY_F3        = 6'd25;
	localparam logic [5:0] KEY_F4        = 6'd26;
	localparam logic [5:0] KEY_F5        = 6'd27;
	localparam logic [5:0] KEY_F6        = 6'd28;
	localparam logic [5:0] KEY_F7        = 6'd29;
	localparam logic [5:0] KEY_F8        = 6'd30;
	localparam logic [5:0] KEY_F9        = 6'd31;
	localparam logic [5:0] KEY_F10       = 6'd32;
	localparam logic [5:0] KEY_F11       = 6'd33;
	localparam logic [5:0] KEY_F12       = 6'd34;

	localparam logic [2:0] MOD_NONE = 3'd0;
	localparam logic [2:0] MOD_ALT  = 3'd2;
	localparam logic [2:0] MOD_CTRL = 3'd4;

	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_DEL    = 8'h7F;
	localparam logic [7:0] BYTE_LBRACK = 8'h5B;
	localparam logic [7:0] BYTE_O      = 8'h4F;
	localparam logic [7:0] BYTE_TILDE  = 8'h7E;
	localparam logic [7:0] BYTE_SEMI   = 8'h3B;
	localparam logic [7:0] BYTE_ZERO   = 8'h30;
	localparam logic [7:0] BYTE_NINE   = 8'h39;
	localparam logic [7:0] BYTE_LT     = 8'h3C;
	localparam logic [7:0] BYTE_EQ     = 8'h3D;
	localparam logic [7:0] BYTE_GT     = 8'h3E;
	localparam logic [7:0] BYTE_QMARK  = 8'h3F;
	localparam logic [7:0] BYTE_FINLO  = 8'h40;

	// Continuation counts of a lead byte; LEAD_NEVER marks a byte that never starts one.
	localparam logic [2:0] LEAD_ASCII = 3'd0;
	localparam logic [2:0] LEAD_NEVER = 3'd4;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_ESC  = 3'd1,
		MODE_CSI  = 3'd2,
		MODE_SS3  = 3'd3,
		MODE_UTF  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_F_LOAD = 2'd1,
		ST_F_PROC = 2'd2,
		ST_F_END  = 2'd3
	} ctl_state_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  key_code;
		logic [20:0] code_point;
		logic [2:0]  modifier_mask;
		logic        last_of_run;
	} out_item_t;

	// One decoded key event before it is marked as last or not.
	typedef struct packed {
		logic        vld;
		logic [5:0]  key;
		logic [20:0] cp;
		logic [2:0]  mods;
	} ev_t;

	typedef struct packed {
		logic feed;
		logic fstart;
		logic fstep;
		logic ffinish;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic at_end;
		logic rem_zero;
	} dp_stat_t;

	function automatic ev_t mk_key(input logic [5:0] key, input logic [2:0] mods);
		ev_t e;
		e.vld  = 1'b1;
		e.key  = key;
		e.cp   = '0;
		e.mods = mods;
		return e;
	endfunction

	function automatic ev_t mk_char(input logic [20:0] cp, input logic [2:0] mods);
		ev_t e;
		e.vld  = 1'b1;
		e.key  = KEY_CHAR;
		e.cp   = cp;
		e.mods = mods;
		return e;
	endfunction

	function automatic logic is_ctrl(input logic [7:0] b);
		return (b < 8'h20) || (b == BYTE_DEL);
	endfunction

	// Event of a control byte, with extra modifiers ORed in.
	function automatic ev_t control_event(input logic [7:0] b, input logic [2:0] extra);
		ev_t e;
		e = '0;
		unique case (b)
			8'h03: e = mk_key(KEY_CTRL_C, MOD_CTRL | extra);
			8'h04: e = mk_key(KEY_CTRL_D, MOD_CTRL | extra);
			8'h08, BYTE_DEL: e = mk_key(KEY_BACKSPACE, extra);
			8'h09: e = mk_key(KEY_TAB, extra);
			8'h0A, 8'h0D: e = mk_key(KEY_ENTER, extra);
			8'h0C: e = mk_key(KEY_CTRL_L, MOD_CTRL | extra);
			8'h12: e = mk_key(KEY_CTRL_R, MOD_CTRL | extra);
			8'h15: e = mk_key(KEY_CTRL_U, MOD_CTRL | extra);
			8'h17: e = mk_key(KEY_CTRL_W, MOD_CTRL | extra);
			8'h1A: e = mk_key(KEY_CTRL_Z, MOD_CTRL | extra);
			BYTE_ESC: e = mk_key(KEY_ESCAPE, extra);
			default: begin
				if (b >= 8'h01 && b <= 8'h1A) begin
					e = mk_char(21'(8'h60 + b), MOD_CTRL | extra);
				end
			end
		endcase
		return e;
	endfunction

	function automatic logic [5:0] letter_key(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			8'h41: k = KEY_UP;
			8'h42: k = KEY_DOWN;
			8'h43: k = KEY_RIGHT;
			8'h44: k = KEY_LEFT;
			8'h46: k = KEY_END;
			8'h48: k = KEY_HOME;
			8'h50: k = KEY_F1;
			8'h51: k = KEY_F2;
			8'h52: k = KEY_F3;
			8'h53: k = KEY_F4;
			8'h5A: k = KEY_BACKTAB;
			default: k = KEY_CHAR;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] tilde_key(input logic [31:0] v);
		logic [5:0] k;
		unique case (v)
			32'd1, 32'd7: k = KEY_HOME;
			32'd2: k = KEY_INSERT;
			32'd3: k = KEY_DELETE;
			32'd4, 32'd8: k = KEY_END;
			32'd5: k = KEY_PAGEUP;
			32'd6: k = KEY_PAGEDOWN;
			32'd11: k = KEY_F1;
			32'd12: k = KEY_F2;
			32'd13: k = KEY_F3;
			32'd14: k = KEY_F4;
			32'd15: k = KEY_F5;
			32'd17: k = KEY_F6;
			32'd18: k = KEY_F7;
			32'd19: k = KEY_F8;
			32'd20: k = KEY_F9;
			32'd21: k = KEY_F10;
			32'd23: k = KEY_F11;
			32'd24: k = KEY_F12;
			default: k = KEY_CHAR;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] lead_extra(input logic [7:0] b);
		logic [2:0] n;
		priority if (b[7] == 1'b0) n = LEAD_ASCII;
		else if (b[7:5] == 3'b110) n = 3'd1;
		else if (b[7:4] == 4'b1110) n = 3'd2;
		else if (b[7:3] == 5'b11110) n = 3'd3;
		else n = LEAD_NEVER;
		return n;
	endfunction

	function automatic logic [20:0] lead_bits(input logic [7:0] b, input logic [1:0] n);
		logic [20:0] r;
		unique case (n)
			2'd1: r = 21'(b[4:0]);
			2'd2: r = 21'(b[3:0]);
			default: r = 21'(b[2:0]);
		endcase
		return r;
	endfunction

	// Final check of a decoded sequence: bad bytes, overlong forms, surrogates, range.
	function automatic logic [20:0] utf8_finish(input logic [20:0] acc, input logic [1:0] n,
			input logic bad);
		logic rep;
		rep = bad
			|| (n == 2'd1 && acc < 21'h80)
			|| (n == 2'd2 && acc < 21'h800)
			|| (n == 2'd3 && acc < 21'h10000)
			|| (acc >= 21'hD800 && acc <= 21'hDFFF)
			|| (acc > 21'h10FFFF);
		return rep ? REPLACEMENT : acc;
	endfunction

endpackage

FILE: design/tksd_ctrl.sv
// Controller of the terminal key sequence decoder: handshake and flush sequencing.
// Depends on tksd_pkg; drives the datapath tksd_dp through ctl_cmd_t.
module tksd_ctrl
	import tksd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_command,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					if (in_command) begin
						cmd.fstart = 1'b1;
						state_d    = ST_F_LOAD;
					end else begin
						cmd.feed = 1'b1;
					end
				end
			end
			ST_F_LOAD: begin
				state_d = ST_F_PROC;
			end
			ST_F_PROC: begin
				if (stat.out_free) begin
					if (!stat.at_end) begin
						cmd.fstep = 1'b1;
						state_d   = ST_F_LOAD;
					end else if (!stat.rem_zero) begin
						cmd.fstep = 1'b1;
					end else begin
						state_d = ST_F_END;
					end
				end
			end
			ST_F_END: begin
				if (stat.out_free) begin
					cmd.ffinish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: design/tksd_dp.sv
// Datapath of the terminal key sequence decoder: parse state, pending byte store,
// byte decoding and the output register. Depends on tksd_pkg; commanded by tksd_ctrl.
module tksd_dp
	import tksd_pkg::*;
#(
	parameter int MAX_PENDING = DEF_MAX_PENDING,
	parameter int PARAM_BITS  = DEF_PARAM_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] data_byte,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CNT_W = $clog2(MAX_PENDING + 1);
	localparam int IDX_W = $clog2(MAX_PENDING);
	localparam int EV_W  = $clog2(RESULT_LIMIT + 1);

	typedef struct packed {
		mode_t                 mode;
		logic [CNT_W-1:0]      cnt;
		logic [PARAM_BITS-1:0] v0;
		logic [PARAM_BITS-1:0] v1;
		logic                  p0;
		logic                  p1;
		logic [1:0]            fidx;
		logic                  priv;
		logic                  any;
		logic [20:0]           acc;
		logic [1:0]            rem;
		logic [1:0]            len;
		logic                  bad;
		logic                  alt;
	} parse_t;

	parse_t ps_q, fn, ps_d;
	logic [7:0] mem [MAX_PENDING];
	logic [7:0] rd_q;
	logic [CNT_W-1:0] idx_q;
	logic [EV_W-1:0] evcnt_q;
	ev_t held_q;
	logic out_valid_q;
	out_item_t out_q;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0] wr_data;
	ev_t fe, fev;
	logic do_start;
	logic [2:0] sc_ext;
	logic [2:0] sc_mods;
	logic [PARAM_BITS-1:0] vsel;
	logic [PARAM_BITS+3:0] vnew;
	logic [20:0] f_acc;
	logic [1:0] f_rem, f_len;
	logic f_bad;
	logic [2:0] fl_ext;
	logic produce;

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.at_end   = (idx_q == ps_q.cnt);
	assign stat.rem_zero = (ps_q.rem == 2'd0);
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	// Decode of one fed byte against the parse state.
	always_comb begin
		fn       = ps_q;
		fe       = '0;
		do_start = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = ps_q.cnt[IDX_W-1:0];
		wr_data  = data_byte;
		sc_ext   = lead_extra(data_byte);
		sc_mods  = (ps_q.mode == MODE_ESC) ? MOD_ALT : MOD_NONE;
		vsel     = (ps_q.fidx == 2'd0) ? ps_q.v0 : ps_q.v1;
		vnew     = ((PARAM_BITS + 4)'(vsel) << 3) + ((PARAM_BITS + 4)'(vsel) << 1)
			+ (PARAM_BITS + 4)'(data_byte[3:0]);
		if (vnew[PARAM_BITS+3:PARAM_BITS] != 4'd0) begin
			vnew = (PARAM_BITS + 4)'({PARAM_BITS{1'b1}});
		end
		if (ps_q.cnt < CNT_W'(MAX_PENDING)) begin
			wr_en  = 1'b1;
			fn.cnt = ps_q.cnt + 1'b1;
		end
		unique case (ps_q.mode)
			MODE_ESC: begin
				priority if (data_byte == BYTE_LBRACK) begin
					fn.mode = MODE_CSI;
					fn.any  = 1'b0;
				end else if (data_byte == BYTE_O) begin
					fn.mode = MODE_SS3;
				end else if (data_byte == BYTE_ESC) begin
					// A second ESC reports the first and starts over with itself pending.
					fe      = mk_key(KEY_ESCAPE, MOD_NONE);
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = BYTE_ESC;
					fn.cnt  = CNT_W'(1);
				end else if (is_ctrl(data_byte)) begin
					fe = control_event(data_byte, MOD_ALT);
					fn = '0;
				end else begin
					do_start = 1'b1;
				end
			end
			MODE_CSI: begin
				fn.any = 1'b1;
				if (data_byte >= BYTE_FINLO && data_byte <= BYTE_TILDE) begin
					if (!ps_q.priv) begin
						fe.mods = ps_q.p1 ? (ps_q.v1[2:0] - 3'd1) : MOD_NONE;
						fe.key  = (data_byte == BYTE_TILDE) ? tilde_key(32'(ps_q.v0))
							: letter_key(data_byte);
						fe.cp   = '0;
						fe.vld  = (fe.key != KEY_CHAR);
					end
					fn = '0;
				end else begin
					if (!ps_q.any && (data_byte == BYTE_LT || data_byte == BYTE_QMARK
							|| data_byte == BYTE_EQ || data_byte == BYTE_GT)) begin
						fn.priv = 1'b1;
					end
					if (data_byte >= BYTE_ZERO && data_byte <= BYTE_NINE) begin
						if (ps_q.fidx == 2'd0) begin
							fn.v0 = vnew[PARAM_BITS-1:0];
							fn.p0 = 1'b1;
						end else if (ps_q.fidx == 2'd1) begin
							fn.v1 = vnew[PARAM_BITS-1:0];
							fn.p1 = 1'b1;
						end
					end else if (data_byte == BYTE_SEMI) begin
						if (ps_q.fidx != 2'd2) fn.fidx = ps_q.fidx + 2'd1;
					end
				end
			end
			MODE_SS3: begin
				fe.key  = letter_key(data_byte);
				fe.cp   = '0;
				fe.mods = MOD_NONE;
				fe.vld  = (fe.key != KEY_CHAR);
				fn      = '0;
			end
			MODE_UTF: begin
				fn.bad = ps_q.bad | (data_byte[7:6] != 2'b10);
				fn.acc = {ps_q.acc[14:0], data_byte[5:0]};
				fn.rem = ps_q.rem - 2'd1;
				if (ps_q.rem == 2'd1) begin
					fe = mk_char(utf8_finish(fn.acc, ps_q.len, fn.bad),
						ps_q.alt ? MOD_ALT : MOD_NONE);
					fn = '0;
				end
			end
			default: begin
				priority if (data_byte == BYTE_ESC) begin
					fn.mode = MODE_ESC;
				end else if (is_ctrl(data_byte)) begin
					fe = control_event(data_byte, MOD_NONE);
					fn = '0;
				end else begin
					do_start = 1'b1;
				end
			end
		endcase
		// Start of a character, plain or after ESC.
		if (do_start) begin
			if (sc_ext == LEAD_ASCII) begin
				fe = mk_char(21'(data_byte), sc_mods);
				fn = '0;
			end else if (sc_ext == LEAD_NEVER) begin
				fe = mk_char(REPLACEMENT, sc_mods);
				fn = '0;
			end else begin
				fn.mode = MODE_UTF;
				fn.acc  = lead_bits(data_byte, sc_ext[1:0]);
				fn.rem  = sc_ext[1:0];
				fn.len  = sc_ext[1:0];
				fn.bad  = 1'b0;
				fn.alt  = (sc_mods == MOD_ALT);
			end
		end
	end

	// Decode of one stored byte during a flush; a cut-short sequence ends as U+FFFD.
	always_comb begin
		fev    = '0;
		f_acc  = ps_q.acc;
		f_rem  = ps_q.rem;
		f_len  = ps_q.len;
		f_bad  = ps_q.bad;
		fl_ext = lead_extra(rd_q);
		if (stat.at_end) begin
			fev   = mk_char(utf8_finish(ps_q.acc, ps_q.len, 1'b1), MOD_NONE);
			f_rem = 2'd0;
		end else if (ps_q.rem != 2'd0) begin
			f_bad = ps_q.bad | (rd_q[7:6] != 2'b10);
			f_acc = {ps_q.acc[14:0], rd_q[5:0]};
			f_rem = ps_q.rem - 2'd1;
			if (ps_q.rem == 2'd1) fev = mk_char(utf8_finish(f_acc, ps_q.len, f_bad), MOD_NONE);
		end else if (rd_q == BYTE_ESC) begin
			fev = mk_key(KEY_ESCAPE, MOD_NONE);
		end else if (is_ctrl(rd_q)) begin
			fev = control_event(rd_q, MOD_NONE);
		end else if (fl_ext == LEAD_ASCII) begin
			fev = mk_char(21'(rd_q), MOD_NONE);
		end else if (fl_ext == LEAD_NEVER) begin
			fev = mk_char(REPLACEMENT, MOD_NONE);
		end else begin
			f_acc = lead_bits(rd_q, fl_ext[1:0]);
			f_rem = fl_ext[1:0];
			f_len = fl_ext[1:0];
			f_bad = 1'b0;
		end
		produce = fev.vld && (evcnt_q < EV_W'(RESULT_LIMIT));
	end

	// Next parse state by command.
	always_comb begin
		ps_d = ps_q;
		if (cmd.feed) begin
			ps_d = fn;
		end else if (cmd.fstart) begin
			ps_d.rem = 2'd0;
		end else if (cmd.fstep) begin
			ps_d.acc = f_acc;
			ps_d.rem = f_rem;
			ps_d.len = f_len;
			ps_d.bad = f_bad;
		end else if (cmd.ffinish) begin
			ps_d = '0;
		end
	end

	// Pending store: one write port, one registered read port that follows the flush index.
	always_ff @(posedge clk) begin
		if (cmd.feed && wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[idx_q[IDX_W-1:0]];
	end

	// Parse state, flush walk and the held event that waits to learn if it is last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q    <= '0;
			idx_q   <= '0;
			evcnt_q <= '0;
			held_q  <= '0;
		end else begin
			ps_q <= ps_d;
			if (cmd.fstart) begin
				idx_q   <= '0;
				evcnt_q <= '0;
				held_q  <= '0;
			end else if (cmd.fstep) begin
				if (!stat.at_end) idx_q <= idx_q + 1'b1;
				if (produce) begin
					held_q  <= fev;
					evcnt_q <= evcnt_q + 1'b1;
				end
			end else if (cmd.ffinish) begin
				held_q.vld <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.feed && fe.vld) || (cmd.fstep && produce && held_q.vld)
				|| (cmd.ffinish && held_q.vld)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.feed && fe.vld) begin
			out_q <= '{key_code: fe.key, code_point: fe.cp, modifier_mask: fe.mods,
				last_of_run: 1'b1};
		end else if ((cmd.fstep && produce && held_q.vld) || (cmd.ffinish && held_q.vld)) begin
			out_q <= '{key_code: held_q.key, code_point: held_q.cp,
				modifier_mask: held_q.mods, last_of_run: cmd.ffinish};
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ps_q.cnt <= CNT_W'(MAX_PENDING)) else $error("pending count above store depth");
	a_fidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ps_q.fidx <= 2'd2) else $error("CSI field index out of range");
	a_held_counted: assert property (@(posedge clk) disable iff (!arst_n)
		held_q.vld |-> evcnt_q != '0) else $error("held event without count");
	a_feed_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.feed || cmd.fstep || cmd.ffinish) |-> stat.out_free)
		else $error("result loaded into a full output register");
`endif

endmodule

FILE: design/terminal_key_sequence_decoder.sv
// Terminal key sequence decoder: takes one terminal byte (or a flush request) per
// request and returns key events for control bytes, UTF-8 characters, Alt keys, SS3
// and CSI keys. A fed byte yields at most one event; the next request is taken once
// the output register is free. A flush walks the pending byte store through its
// registered read port, a load state and a process state per stored byte, then reads
// past the end, ends any sequence cut short and marks the last event; the input is held
// off until the flush ends, and longer while the receiver stalls. Up to 16 events come
// from one flush, the last marked last_of_run.
// Depends on tksd_pkg, tksd_ctrl and tksd_dp.
module terminal_key_sequence_decoder
	import tksd_pkg::*;
#(
	parameter int MAX_PENDING = DEF_MAX_PENDING,
	parameter int PARAM_BITS  = DEF_PARAM_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequencer.
	tksd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.in_ready   (in_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Decode datapath.
	tksd_dp #(
		.MAX_PENDING (MAX_PENDING),
		.PARAM_BITS  (PARAM_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (in_data.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the terminal key sequence decoder.
// Predicts key events from fed bytes and flush requests and checks every result in order.
// Depends on tksd_pkg and the terminal_key_sequence_decoder RTL.
module testbench;
	import tksd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	// Holds the predicted key events and compares them against the block's results.
	class key_event_scoreboard;
		out_item_t pending_events[$];
		int errors;
		int events_checked;
		int requests_seen;

		// Parser state of the predictor.
		mode_t mode;
		logic [7:0] stored [16];
		int stored_count;
		logic [31:0] param_val [2];
		bit param_set [2];
		int field_idx;
		bit is_private;
		bit csi_seen;
		logic [20:0] utf_acc;
		int utf_left;
		int utf_len;
		bit utf_bad;
		bit utf_alt;
		out_item_t run_events[$];

		function new();
			errors = 0;
			events_checked = 0;
			requests_seen = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode = MODE_IDLE;
			stored_count = 0;
			param_val[0] = 0;
			param_val[1] = 0;
			param_set[0] = 0;
			param_set[1] = 0;
			field_idx = 0;
			is_private = 0;
			csi_seen = 0;
			utf_acc = 0;
			utf_left = 0;
			utf_len = 0;
			utf_bad = 0;
			utf_alt = 0;
		endfunction

		function void add_event(logic [5:0] key, logic [20:0] cp, logic [2:0] mods);
			out_item_t e;
			if (run_events.size() >= RESULT_LIMIT)
				return;
			e.key_code = key;
			e.code_point = cp;
			e.modifier_mask = mods;
			e.last_of_run = 1'b0;
			run_events.insert(run_events.size(), e);
		endfunction

		function void add_control(logic [7:0] b, logic [2:0] extra);
			case (b)
				8'h03: add_event(KEY_CTRL_C, 0, MOD_CTRL | extra);
				8'h04: add_event(KEY_CTRL_D, 0, MOD_CTRL | extra);
				8'h08, BYTE_DEL: add_event(KEY_BACKSPACE, 0, extra);
				8'h09: add_event(KEY_TAB, 0, extra);
				8'h0A, 8'h0D: add_event(KEY_ENTER, 0, extra);
				8'h0C: add_event(KEY_CTRL_L, 0, MOD_CTRL | extra);
				8'h12: add_event(KEY_CTRL_R, 0, MOD_CTRL | extra);
				8'h15: add_event(KEY_CTRL_U, 0, MOD_CTRL | extra);
				8'h17: add_event(KEY_CTRL_W, 0, MOD_CTRL | extra);
				8'h1A: add_event(KEY_CTRL_Z, 0, MOD_CTRL | extra);
				BYTE_ESC: add_event(KEY_ESCAPE, 0, extra);
				default: begin
					if (b >= 8'h01 && b <= 8'h1A)
						add_event(KEY_CHAR, 21'h60 + b, MOD_CTRL | extra);
				end
			endcase
		endfunction

		function logic [5:0] final_letter(logic [7:0] c);
			case (c)
				"A": return KEY_UP;
				"B": return KEY_DOWN;
				"C": return KEY_RIGHT;
				"D": return KEY_LEFT;
				"F": return KEY_END;
				"H": return KEY_HOME;
				"P": return KEY_F1;
				"Q": return KEY_F2;
				"R": return KEY_F3;
				"S": return KEY_F4;
				"Z": return KEY_BACKTAB;
				default: return KEY_CHAR;
			endcase
		endfunction

		function logic [5:0] tilde_code(logic [31:0] v);
			case (v)
				1, 7: return KEY_HOME;
				2: return KEY_INSERT;
				3: return KEY_DELETE;
				4, 8: return KEY_END;
				5: return KEY_PAGEUP;
				6: return KEY_PAGEDOWN;
				11: return KEY_F1;
				12: return KEY_F2;
				13: return KEY_F3;
				14: return KEY_F4;
				15: return KEY_F5;
				17: return KEY_F6;
				18: return KEY_F7;
				19: return KEY_F8;
				20: return KEY_F9;
				21: return KEY_F10;
				23: return KEY_F11;
				24: return KEY_F12;
				default: return KEY_CHAR;
			endcase
		endfunction

		function int follow_count(logic [7:0] b);
			if (!b[7])
				return 0;
			if (b[7:5] == 3'b110)
				return 1;
			if (b[7:4] == 4'b1110)
				return 2;
			if (b[7:3] == 5'b11110)
				return 3;
			return 4;
		endfunction

		function logic [20:0] head_bits(logic [7:0] b, int n);
			if (n == 1)
				return b & 8'h1F;
			if (n == 2)
				return b & 8'h0F;
			return b & 8'h07;
		endfunction

		function logic [20:0] scalar_check(logic [20:0] acc, int n, bit bad);
			if (bad || (n == 1 && acc < 21'h80) || (n == 2 && acc < 21'h800)
					|| (n == 3 && acc < 21'h10000) || (acc >= 21'hD800 && acc <= 21'hDFFF)
					|| acc > 21'h10FFFF)
				return REPLACEMENT;
			return acc;
		endfunction

		function void begin_char(logic [7:0] b, bit alt);
			int n;
			n = follow_count(b);
			if (n == 0) begin
				add_event(KEY_CHAR, b, alt ? MOD_ALT : MOD_NONE);
				clear_state();
			end else if (n == 4) begin
				add_event(KEY_CHAR, REPLACEMENT, alt ? MOD_ALT : MOD_NONE);
				clear_state();
			end else begin
				mode = MODE_UTF;
				utf_acc = head_bits(b, n);
				utf_left = n;
				utf_len = n;
				utf_bad = 0;
				utf_alt = alt;
			end
		endfunction

		function void csi_step(logic [7:0] b);
			bit first;
			logic [2:0] mods;
			logic [5:0] key;
			logic [32:0] v;
			first = !csi_seen;
			csi_seen = 1;
			if (b >= BYTE_FINLO && b <= BYTE_TILDE) begin
				if (!is_private) begin
					mods = param_set[1] ? 3'(param_val[1] - 1) : MOD_NONE;
					key = (b == BYTE_TILDE) ? tilde_code(param_val[0]) : final_letter(b);
					if (key != KEY_CHAR)
						add_event(key, 0, mods);
				end
				clear_state();
				return;
			end
			if (first && (b == BYTE_LT || b == BYTE_QMARK || b == BYTE_EQ || b == BYTE_GT))
				is_private = 1;
			if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
				if (field_idx < 2) begin
					v = param_val[field_idx] * 10 + (b - BYTE_ZERO);
					if (v > 33'hFFFF)
						v = 33'hFFFF;
					param_val[field_idx] = v[31:0];
					param_set[field_idx] = 1;
				end
			end else if (b == BYTE_SEMI && field_idx < 2) begin
				field_idx++;
			end
		endfunction

		function void feed(logic [7:0] b);
			logic [5:0] key;
			if (stored_count < 16)
				stored[stored_count++] = b;
			case (mode)
				MODE_ESC: begin
					if (b == BYTE_LBRACK) begin
						mode = MODE_CSI;
						csi_seen = 0;
					end else if (b == BYTE_O) begin
						mode = MODE_SS3;
					end else if (b == BYTE_ESC) begin
						add_event(KEY_ESCAPE, 0, MOD_NONE);
						stored[0] = BYTE_ESC;
						stored_count = 1;
					end else if (b < 8'h20 || b == BYTE_DEL) begin
						add_control(b, MOD_ALT);
						clear_state();
					end else begin
						begin_char(b, 1);
					end
				end
				MODE_CSI: csi_step(b);
				MODE_SS3: begin
					key = final_letter(b);
					if (key != KEY_CHAR)
						add_event(key, 0, MOD_NONE);
					clear_state();
				end
				MODE_UTF: begin
					if (b[7:6] != 2'b10)
						utf_bad = 1;
					utf_acc = {utf_acc[14:0], b[5:0]};
					if (utf_left > 0)
						utf_left--;
					if (utf_left == 0) begin
						add_event(KEY_CHAR, scalar_check(utf_acc, utf_len, utf_bad),
							utf_alt ? MOD_ALT : MOD_NONE);
						clear_state();
					end
				end
				default: begin
					if (b == BYTE_ESC) begin
						mode = MODE_ESC;
					end else if (b < 8'h20 || b == BYTE_DEL) begin
						add_control(b, MOD_NONE);
						clear_state();
					end else begin
						begin_char(b, 0);
					end
				end
			endcase
		endfunction

		function void flush();
			int i;
			int n;
			int k;
			logic [7:0] b;
			logic [20:0] acc;
			bit bad;
			i = 0;
			while (i < stored_count) begin
				b = stored[i++];
				bad = 0;
				if (b == BYTE_ESC) begin
					add_event(KEY_ESCAPE, 0, MOD_NONE);
					continue;
				end
				if (b < 8'h20 || b == BYTE_DEL) begin
					add_control(b, MOD_NONE);
					continue;
				end
				n = follow_count(b);
				if (n == 0) begin
					add_event(KEY_CHAR, b, MOD_NONE);
					continue;
				end
				if (n == 4) begin
					add_event(KEY_CHAR, REPLACEMENT, MOD_NONE);
					continue;
				end
				acc = head_bits(b, n);
				for (k = 0; k < n; k++) begin
					if (i >= stored_count) begin
						bad = 1;
						break;
					end
					b = stored[i++];
					if (b[7:6] != 2'b10)
						bad = 1;
					acc = {acc[14:0], b[5:0]};
				end
				add_event(KEY_CHAR, scalar_check(acc, n, bad), MOD_NONE);
			end
			clear_state();
		endfunction

		// Notes one accepted request and queues the events it must cause.
		function void note_request(in_item_t req);
			run_events.delete();
			requests_seen++;
			if (req.command)
				flush();
			else
				feed(req.data_byte);
			if (run_events.size() > 0)
				run_events[run_events.size() - 1].last_of_run = 1'b1;
			foreach (run_events[j])
				pending_events.insert(pending_events.size(), run_events[j]);
		endfunction

		// Checks one accepted result against the oldest expected event.
		function void check_event(out_item_t got);
			out_item_t want;
			events_checked++;
			if (pending_events.size() == 0) begin
				$error("unexpected result key_code=%0d code_point=%h", got.key_code,
					got.code_point);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			if (got.key_code !== want.key_code) begin
				$error("key_code expected %0d actual %0d", want.key_code, got.key_code);
				errors++;
			end
			if (got.code_point !== want.code_point) begin
				$error("code_point expected %h actual %h", want.code_point, got.code_point);
				errors++;
			end
			if (got.modifier_mask !== want.modifier_mask) begin
				$error("modifier_mask expected %0d actual %0d", want.modifier_mask,
					got.modifier_mask);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run expected %0d actual %0d", want.last_of_run,
					got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	key_event_scoreboard board;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	int cycle_count;

	terminal_key_sequence_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Cycle limit guards against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("terminal_key_sequence_decoder: mismatch");
			$finish;
		end
	end

	// Accepted requests update the predictor; accepted results are checked.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_request(in_data);
		if (arst_n && out_valid && out_ready)
			board.check_event(out_data);
	end

	// Receiver readiness: random stalls, or a long hold-off when asked.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one request and holds it until it is accepted. Valid stays high after
	// acceptance so that a following request can take over in the same step; idle
	// cycles and the drain wait drop it.
	task automatic send_request(logic cmd, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data.command <= cmd;
		in_data.data_byte <= b;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_bytes(byte unsigned seq[$]);
		foreach (seq[i])
			send_request(1'b0, seq[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_events.size() != 0)
			@(negedge clk);
		repeat (40)
			@(negedge clk);
	endtask

	// Sends a plausible key sequence with random content.
	task automatic send_random_sequence();
		byte unsigned seq[$];
		int kind;
		int n;
		kind = $urandom_range(9);
		case (kind)
			0: seq = '{8'($urandom_range(31))};
			1: seq = '{8'($urandom_range(8'h20, 8'h7F))};
			2: seq = '{BYTE_ESC, 8'($urandom_range(255))};
			3: seq = '{BYTE_ESC, BYTE_O, 8'($urandom_range(8'h40, 8'h5A))};
			4, 5: begin
				seq = '{BYTE_ESC, BYTE_LBRACK};
				if ($urandom_range(5) == 0)
					seq.insert(seq.size(), 8'($urandom_range(BYTE_LT, BYTE_QMARK)));
				n = $urandom_range(2);
				repeat (n)
					seq.insert(seq.size(), 8'($urandom_range(BYTE_ZERO, BYTE_NINE)));
				if ($urandom_range(1)) begin
					seq.insert(seq.size(), BYTE_SEMI);
					seq.insert(seq.size(), 8'($urandom_range(BYTE_ZERO, BYTE_NINE)));
				end
				if ($urandom_range(9) == 0)
					seq.insert(seq.size(), 8'($urandom_range(8'h20, 8'h2F)));
				seq.insert(seq.size(), $urandom_range(1) ? BYTE_TILDE :
					8'($urandom_range(8'h40, 8'h5A)));
			end
			6: seq = '{8'($urandom_range(8'hC2, 8'hDF)), 8'($urandom_range(8'h80, 8'hBF))};
			7: seq = '{8'($urandom_range(8'hE0, 8'hEF)), 8'($urandom_range(8'h80, 8'hBF)),
				8'($urandom_range(8'h80, 8'hBF))};
			8: seq = '{8'($urandom_range(8'hF0, 8'hF7)), 8'($urandom_range(8'h80, 8'hBF)),
				8'($urandom_range(8'h80, 8'hBF)), 8'($urandom_range(8'h80, 8'hBF))};
			default: seq = '{8'($urandom_range(255))};
		endcase
		// Now and then a sequence is cut short by a flush.
		if (seq.size() > 1 && $urandom_range(7) == 0) begin
			n = $urandom_range(seq.size() - 1, 1);
			while (seq.size() > n)
				void'(seq.pop_back());
			send_bytes(seq);
			send_request(1'b1, 8'($urandom_range(255)));
		end else begin
			send_bytes(seq);
		end
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		int sent;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = board.requests_seen;
		while (board.requests_seen - sent < count)
			send_random_sequence();
	endtask

	initial begin
		byte unsigned longrun[$];
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		cycle_count = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: controls, Alt keys, CSI and SS3 keys, UTF-8 edge cases.
		send_bytes('{8'h00, 8'h03, 8'h7F, 8'hFF, 8'h1F});
		send_bytes('{BYTE_ESC, BYTE_ESC, 8'h61});
		send_bytes('{BYTE_ESC, BYTE_LBRACK, "9", "9", "9", "9", "9", "9", BYTE_SEMI,
			"0", BYTE_TILDE});
		send_bytes('{BYTE_ESC, BYTE_LBRACK, "1", BYTE_SEMI, "5", "A"});
		send_bytes('{BYTE_ESC, BYTE_LBRACK, BYTE_QMARK, "2", "5", "h"});
		send_bytes('{BYTE_ESC, BYTE_O, "P"});
		send_bytes('{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80});
		send_bytes('{BYTE_ESC, 8'hE2, 8'h82, 8'hAC});
		send_bytes('{BYTE_ESC, BYTE_LBRACK, "3"});
		send_request(1'b1, 8'h00);
		wait_drained();

		// Overflow the pending store, then flush with many events waiting.
		longrun = '{BYTE_ESC, BYTE_LBRACK};
		repeat (18)
			longrun.insert(longrun.size(), 8'($urandom_range(8'h20, 8'h3F)));
		send_bytes(longrun);
		send_request(1'b1, 8'hFF);
		wait_drained();

		// Long receiver hold-off while requests keep coming.
		hold_off_cycles = 300;
		run_phase(0, 0, 30);
		wait_drained();

		run_phase(0, 0, 32);
		run_phase(46, 0, 32);
		run_phase(0, 46, 32);
		run_phase(30, 30, 32);
		send_request(1'b1, 8'h00);
		wait_drained();

		$display("Covered %0d requests and %0d results: controls, Alt, CSI, SS3, UTF-8, flush.",
			board.requests_seen, board.events_checked);
		if (board.errors == 0 && board.pending_events.size() == 0)
			$display("terminal_key_sequence_decoder: match");
		else
			$display("terminal_key_sequence_decoder: mismatch");
		$finish;
	end
endmodule

FILE: terminal_key_sequence_decoder.f
design/tksd_pkg.sv
design/tksd_ctrl.sv
design/tksd_dp.sv
design/terminal_key_sequence_decoder.sv
dv/testbench.sv
